@@ rtl/core/spca_pkg.sv @@
// Shared types and constants for the SGM path cost aggregation block.
package spca_pkg;

  localparam int unsigned AGG_W   = 13;
  localparam int unsigned COST_W  = 8;
  localparam int unsigned P1_W    = 8;
  localparam int unsigned P2_W    = 12;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [AGG_W-1:0] AGG_MAX = {AGG_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_SMALL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_LARGE = 1'd1;

  localparam logic [P1_W-1:0] P1_RESET = 8'd10;
  localparam logic [P2_W-1:0] P2_RESET = 12'd120;

  typedef struct packed {
    logic path_start;
    logic has_left;
    logic has_right;
  } nbr_flags_t;

endpackage

@@ rtl/core/spca_row_mem.sv @@
// Row store of the previous pixel's aggregated costs, with a registered read.
module spca_row_mem
  import spca_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [AGG_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [AGG_W-1:0] rdata
);

  logic [AGG_W-1:0] mem [DEPTH];
  logic [AGG_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/spca_cost_unit.sv @@
// Aggregated cost datapath: minimum of the four path terms, add, normalise and clamp, or the raw cost at a path start.
module spca_cost_unit
  import spca_pkg::*;
(
  input  logic [COST_W-1:0] cost,
  input  logic [AGG_W-1:0]  here,
  input  logic [AGG_W-1:0]  left,
  input  logic [AGG_W-1:0]  right,
  input  logic [AGG_W-1:0]  pmin,
  input  logic [P1_W-1:0]   p1,
  input  logic [P2_W-1:0]   p2,
  input  nbr_flags_t        flags,
  output logic [AGG_W-1:0]  agg
);

  logic [AGG_W:0]   t_left;
  logic [AGG_W:0]   t_right;
  logic [AGG_W:0]   t_jump;
  logic [AGG_W:0]   best_a;
  logic [AGG_W:0]   best_b;
  logic [AGG_W:0]   best;
  logic [AGG_W+1:0] sum;
  logic [AGG_W+1:0] diff;

  always_comb begin
    t_left  = {1'b0, left} + {{(AGG_W+1-P1_W){1'b0}}, p1};
    t_right = {1'b0, right} + {{(AGG_W+1-P1_W){1'b0}}, p1};
    t_jump  = {1'b0, pmin} + {{(AGG_W+1-P2_W){1'b0}}, p2};

    best_a = {1'b0, here};
    if (flags.has_left && (t_left < best_a)) begin
      best_a = t_left;
    end
    best_b = t_jump;
    if (flags.has_right && (t_right < best_b)) begin
      best_b = t_right;
    end
    best = (best_b < best_a) ? best_b : best_a;

    sum = {1'b0, best} + {{(AGG_W+2-COST_W){1'b0}}, cost};
    if (sum > {2'b00, pmin}) begin
      diff = sum - {2'b00, pmin};
    end else begin
      diff = '0;
    end

    if (flags.path_start) begin
      agg = {{(AGG_W-COST_W){1'b0}}, cost};
    end else if (diff > {2'b00, AGG_MAX}) begin
      agg = AGG_MAX;
    end else begin
      agg = diff[AGG_W-1:0];
    end
  end

endmodule

@@ rtl/core/sgm_path_cost_aggregation_top.sv @@
// Top level of the SGM path cost aggregation block: control, row store and result register.
// A result is registered on its input transfer and is presented in the next cycle.
// Throughput: one cost per cycle while in_stall is low; the single row memory read issued two
// disparities ahead supplies the neighbour at disparity plus one, so no cycle is lost at pixel boundaries.
// Reset: control state clears, penalties return to 10 and 120; the row store is not cleared
// and needs no clearing pass, since the first pixel of a path never reads it.
module sgm_path_cost_aggregation_top
  import spca_pkg::*;
#(
  parameter int unsigned NUM_DISPARITIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COST_W-1:0]    in_cost,
  input  logic                 in_start_path,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AGG_W-1:0]     out_agg_cost,
  output logic                 out_last_of_pixel,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned IW = (NUM_DISPARITIES > 1) ? $clog2(NUM_DISPARITIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_DISPARITIES - 1);
  localparam logic [IW:0]   DEPTH_W  = (IW+1)'(NUM_DISPARITIES);

  logic [P1_W-1:0]  p1_r;
  logic [P2_W-1:0]  p2_r;
  logic [IW-1:0]    idx_r;
  logic             path_start_r;
  logic [AGG_W-1:0] left_r;
  logic [AGG_W-1:0] here_r;
  logic [AGG_W-1:0] pmin_r;
  logic [AGG_W-1:0] rmin_r;
  logic             out_valid_r;
  logic [AGG_W-1:0] out_agg_r;
  logic             out_last_r;

  logic             in_acc;
  logic [IW-1:0]    eff_idx;
  logic             eff_last;
  logic             eff_ps;
  logic [IW:0]      ahead_sum;
  logic [IW-1:0]    raddr;
  logic [AGG_W-1:0] right_old;
  logic [AGG_W-1:0] agg;
  logic [AGG_W-1:0] rmin_base;
  logic [AGG_W-1:0] rmin_nxt;
  nbr_flags_t       flags;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    eff_idx   = in_start_path ? '0 : idx_r;
    eff_last  = (eff_idx == LAST_IDX);
    eff_ps    = in_start_path || path_start_r;
    ahead_sum = {1'b0, eff_idx} + (IW+1)'(2);
    if (ahead_sum >= DEPTH_W) begin
      raddr = IW'(ahead_sum - DEPTH_W);
    end else begin
      raddr = ahead_sum[IW-1:0];
    end
    flags.path_start = eff_ps;
    flags.has_left   = (eff_idx != '0);
    flags.has_right  = !eff_last;
  end

  always_comb begin
    rmin_base = in_start_path ? AGG_MAX : rmin_r;
    rmin_nxt  = (agg < rmin_base) ? agg : rmin_base;
  end

  spca_row_mem #(
    .DEPTH (NUM_DISPARITIES),
    .AW    (IW)
  ) u_row_mem (
    .clk   (clk),
    .we    (in_acc),
    .waddr (eff_idx),
    .wdata (agg),
    .re    (in_acc),
    .raddr (raddr),
    .rdata (right_old)
  );

  spca_cost_unit u_cost_unit (
    .cost  (in_cost),
    .here  (here_r),
    .left  (left_r),
    .right (right_old),
    .pmin  (pmin_r),
    .p1    (p1_r),
    .p2    (p2_r),
    .flags (flags),
    .agg   (agg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= P1_RESET;
      p2_r <= P2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PENALTY_SMALL: p1_r <= cfg_wdata[P1_W-1:0];
        REG_PENALTY_LARGE: p2_r <= cfg_wdata[P2_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      path_start_r <= 1'b1;
      left_r       <= '0;
      pmin_r       <= '0;
      rmin_r       <= AGG_MAX;
    end else if (in_acc) begin
      left_r <= here_r;
      if (eff_last) begin
        idx_r        <= '0;
        path_start_r <= 1'b0;
        pmin_r       <= rmin_nxt;
        rmin_r       <= AGG_MAX;
      end else begin
        idx_r        <= eff_idx + IW'(1);
        path_start_r <= eff_ps;
        rmin_r       <= rmin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      here_r <= right_old;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_agg_r  <= agg;
      out_last_r <= eff_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_agg_cost      = out_agg_r;
  assign out_last_of_pixel = out_last_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, idx_r} < DEPTH_W)
    else $error("disparity index out of range");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && eff_last |=> (idx_r == '0) && !path_start_r && out_last_of_pixel)
    else $error("end of pixel did not wrap the index and clear the path start");

  a_start_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_start_path && !eff_last |=> path_start_r && (idx_r == IW'(1)))
    else $error("path start did not restart the pixel");

  a_start_passes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && eff_ps |=> out_valid && (out_agg_cost == {{(AGG_W-COST_W){1'b0}}, $past(in_cost)}))
    else $error("path start pixel did not pass its cost through");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the SGM path cost aggregation block.
`timescale 1ns / 1ps

module tb_top;
  import spca_pkg::*;

  localparam int unsigned ND = 256;
  localparam int unsigned IDX_W = $clog2(ND);
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [AGG_W-1:0] agg;
    logic             is_last;
  } agg_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [COST_W-1:0]    in_cost;
  logic                 in_start_path;
  logic                 out_valid;
  logic                 out_stall;
  logic [AGG_W-1:0]     out_agg_cost;
  logic                 out_last_of_pixel;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Shadow copy of the block's state and penalty registers.
  logic [AGG_W-1:0] row_store [ND];
  logic [AGG_W-1:0] left_prev;
  logic [AGG_W-1:0] prior_min;
  logic [AGG_W-1:0] run_min;
  int unsigned      disp_idx;
  logic             fresh_path;
  logic [P1_W-1:0]  p_small;
  logic [P2_W-1:0]  p_large;

  agg_result_t pending_costs[$];
  int unsigned cycles;
  int unsigned errors;
  int unsigned items_in;
  int unsigned results_out;
  int unsigned settings_used;
  bit          calm;

  sgm_path_cost_aggregation_top #(
    .NUM_DISPARITIES(ND)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cost          (in_cost),
    .in_start_path    (in_start_path),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_agg_cost     (out_agg_cost),
    .out_last_of_pixel(out_last_of_pixel),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_costs.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic agg_result_t aggregate_cost(input logic [COST_W-1:0] c, input logic s);
    int unsigned      d;
    int unsigned      best;
    int unsigned      cand;
    int unsigned      sum;
    int unsigned      agg;
    logic             is_last;
    logic [IDX_W-1:0] di;
    agg_result_t      r;
    if (s) begin
      disp_idx = 0;
      run_min = AGG_MAX;
      fresh_path = 1'b1;
    end
    if (disp_idx >= ND) disp_idx = 0;
    d = disp_idx;
    di = d[IDX_W-1:0];
    is_last = (d == ND - 1);
    if (fresh_path) begin
      agg = c;
    end else begin
      best = row_store[di];
      if (d > 0) begin
        cand = int'(left_prev) + int'(p_small);
        if (cand < best) best = cand;
      end
      if (!is_last) begin
        cand = int'(row_store[di + IDX_W'(1)]) + int'(p_small);
        if (cand < best) best = cand;
      end
      cand = int'(prior_min) + int'(p_large);
      if (cand < best) best = cand;
      sum = int'(c) + best;
      agg = (sum > prior_min) ? sum - prior_min : 0;
      if (agg > AGG_MAX) agg = AGG_MAX;
    end
    left_prev = row_store[di];
    row_store[di] = agg[AGG_W-1:0];
    if (agg[AGG_W-1:0] < run_min) run_min = agg[AGG_W-1:0];
    if (is_last) begin
      prior_min = run_min;
      run_min = AGG_MAX;
      disp_idx = 0;
      fresh_path = 1'b0;
    end else begin
      disp_idx = d + 1;
    end
    r.agg = agg[AGG_W-1:0];
    r.is_last = is_last;
    return r;
  endfunction

  // Configuration, input transfers and result transfers are all observed here, in that order.
  always @(posedge clk) begin
    agg_result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PENALTY_SMALL: p_small = cfg_wdata[P1_W-1:0];
          REG_PENALTY_LARGE: p_large = cfg_wdata[P2_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_costs.push_back(aggregate_cost(in_cost, in_start_path));
        items_in++;
      end
      if (out_valid && !out_stall) begin
        results_out++;
        if (pending_costs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result agg_cost %0d last_of_pixel %0b", $time,
                   out_agg_cost, out_last_of_pixel);
        end else begin
          want = pending_costs.pop_front();
          if (out_agg_cost !== want.agg) begin
            errors++;
            $display("%0t: agg_cost expected %0d actual %0d", $time, want.agg, out_agg_cost);
          end
          if (out_last_of_pixel !== want.is_last) begin
            errors++;
            $display("%0t: last_of_pixel expected %0b actual %0b", $time, want.is_last,
                     out_last_of_pixel);
          end
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int unsigned n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  task automatic idle_input(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_cost <= COST_W'($urandom_range(0, 255));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_cost(input logic [COST_W-1:0] c, input logic s);
    idle_input(pick_gap());
    @(negedge clk);
    in_valid <= 1'b1;
    in_cost <= c;
    in_start_path <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_penalties(input logic [CFG_W-1:0] small_val,
                               input logic [CFG_W-1:0] large_val);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_PENALTY_SMALL;
    cfg_wdata <= small_val;
    @(negedge clk);
    cfg_index <= REG_PENALTY_LARGE;
    cfg_wdata <= large_val;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input bit first, input int unsigned mode, input bit noisy,
                            input bit pause_midway, input int unsigned count);
    int walk;
    logic [COST_W-1:0] c;
    logic s;
    walk = $urandom_range(0, 255);
    for (int unsigned d = 0; d < count; d++) begin
      case (mode)
        0: c = COST_W'($urandom_range(0, 255));
        1: begin
          walk = walk + int'($urandom_range(0, 8)) - 4;
          if (walk < 0) walk = 0;
          if (walk > 255) walk = 255;
          c = walk[COST_W-1:0];
        end
        default: c = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      s = (first && d == 0) || (noisy && $urandom_range(0, 199) == 0);
      send_cost(c, s);
      if (pause_midway && d == count / 2) drain_results();
    end
  endtask

  task automatic test_first_pixel_passthrough();
    send_cost(8'd0, 1'b1);
    send_cost(8'd255, 1'b0);
    send_cost(8'd0, 1'b0);
    send_cost(8'd255, 1'b0);
    send_cost(8'h55, 1'b0);
    send_cost(8'hAA, 1'b0);
    send_cost(8'd1, 1'b0);
    send_cost(8'd254, 1'b0);
  endtask

  task automatic test_restart_mid_pixel();
    send_cost(8'd200, 1'b1);
    send_cost(8'd3, 1'b0);
    send_cost(8'd128, 1'b0);
    send_cost(8'd77, 1'b1);
    send_cost(8'd255, 1'b0);
    send_cost(8'd0, 1'b0);
    send_cost(8'd17, 1'b1);
    send_cost(8'd90, 1'b0);
    drain_results();
  endtask

  task automatic test_random_paths();
    // The first two pixels run on the reset penalties.
    calm = 1'b1;
    send_pixel(1'b1, 0, 1'b0, 1'b0, ND);
    calm = 1'b0;
    send_pixel(1'b0, 1, 1'b0, 1'b0, ND);
    set_penalties(12'd0, 12'd0);
    send_pixel(1'b0, 0, 1'b0, 1'b0, ND / 2);
    set_penalties(12'hFFF, 12'hFFF);
    send_pixel(1'b0, 2, 1'b0, 1'b1, ND / 2);
    set_penalties(CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)));
    send_pixel(1'b0, $urandom_range(0, 2), 1'b1, 1'b0, ND / 2);
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cost = '0;
    in_start_path = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PENALTY_SMALL;
    cfg_wdata = '0;
    cycles = 0;
    errors = 0;
    items_in = 0;
    results_out = 0;
    settings_used = 1;
    calm = 1'b0;
    for (int i = 0; i < ND; i++) row_store[i[IDX_W-1:0]] = '0;
    left_prev = '0;
    prior_min = '0;
    run_min = AGG_MAX;
    disp_idx = 0;
    fresh_path = 1'b1;
    p_small = P1_RESET;
    p_large = P2_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_pixel_passthrough();
    test_restart_mid_pixel();
    test_random_paths();

    repeat (5) @(posedge clk);
    $display("Sent %0d cost transfers over %0d penalty settings, with mid-pixel restarts.",
             items_in, settings_used);
    $display("Checked %0d results, %0d mismatches.", results_out, errors);
    if (errors == 0 && pending_costs.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
